@@ design/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Command, status codes and field widths used by the channel interfaces
// and the queue logic.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int ValueWidth = 32;

   typedef logic [1:0]                    cmd_type;
   typedef logic [1:0]                    status_type;
   typedef logic signed [ValueWidth-1:0]  value_type;
   typedef logic [2:0]                    count_type;

   localparam cmd_type CMD_PUSH = 2'd0;
   localparam cmd_type CMD_POP  = 2'd1;
   localparam cmd_type CMD_PEEK = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_OVER  = 2'd1;
   localparam status_type STATUS_UNDER = 2'd2;

endpackage

@@ design/spq_if.sv @@
// ---------------------------------------------------------------------------
// spq_if: command and response channels of the sorted priority queue
// Valid/ready channels; a word moves on a clock edge with both high.
// ---------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic      valid;
   logic      ready;
   cmd_type   cmd;
   value_type push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   value_type  top_value;
   count_type  entry_count;

   modport source (output valid, output status, output top_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input top_value, input entry_count,
                   output ready);
endinterface

@@ design/sorted_priority_queue.sv @@
// ---------------------------------------------------------------------------
// sorted_priority_queue: bounded max-priority queue on a sorted memory
// Entries sit in ascending order in a one-port-read, one-port-write memory.
// Push shifts larger entries up one per cycle; pop/peek read the top entry.
//
//   channel | dir | handshake        | word
//   --------+-----+------------------+----------------------------------
//   req     | in  | req.valid/ready  | cmd, push_value
//   rsp     | out | rsp.valid/ready  | status, top_value, entry_count
//
// One command at a time. Push moves each larger entry up by one, then writes
// the new value in the hole; pop and peek read the top entry; rejected and
// unused commands go straight to the reply. The entry memory's single read and
// write port sets the push time. Reset (synchronous) empties the queue; the
// memory itself is not cleared. A stalled response holds in the output
// register and the next command waits for it only at its final step.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH = 4
) (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);
   import spq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_TOP_RD,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   value_type     val_ff, val_in;
   cmd_type       cmd_ff, cmd_in;
   status_type    res_status_ff, res_status_in;
   value_type     res_top_ff, res_top_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_top_ff, rsp_top_in;
   count_type     rsp_count_ff, rsp_count_in;

   value_type     entries_ff [DEPTH];
   value_type     rd_data_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   value_type     mem_wdata;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          out_free;

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.top_value   = rsp_top_ff;
   assign rsp.entry_count = rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cmd_in        = cmd_ff;
      res_status_in = res_status_ff;
      res_top_in    = res_top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = val_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff - IW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               val_in        = req.push_value;
               cmd_in        = req.cmd;
               res_status_in = STATUS_OK;
               res_top_in    = '0;
               state_in      = ST_FINISH;
               case (req.cmd)
                  CMD_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        res_status_in = STATUS_OVER;
                     end else begin
                        pos_in   = IW'(count_ff);
                        state_in = ST_PUSH_RD;
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_UNDER;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IW'(count_ff - CW'(1));
                        state_in = ST_TOP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PUSH_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_PUSH_CMP;
            end
         end
         ST_PUSH_CMP: begin
            // rd_data_ff holds the entry just below the hole at pos_ff
            if (val_ff < rd_data_ff) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff;
               pos_in    = pos_ff - IW'(1);
               if (pos_ff == IW'(1)) begin
                  state_in = ST_PUSH_RD;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - IW'(2);
               end
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_FINISH;
            end
         end
         ST_TOP_RD: begin
            res_top_in = rd_data_ff;
            if (cmd_ff == CMD_POP) begin
               count_in = count_ff - CW'(1);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_top_in    = res_top_ff;
               rsp_count_in  = 3'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cmd_ff        <= cmd_in;
      res_status_ff <= res_status_in;
      res_top_ff    <= res_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

endmodule

@@ verif/spq_tb_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_tb_pkg: shadow queue and reply checking for the priority queue bench
// Keeps a sorted shadow copy of the queue contents, works out the reply
// each accepted command should produce, and checks replies in order.
// ---------------------------------------------------------------------------
package spq_tb_pkg;
   import spq_pkg::*;

   // cmd encoding the block must ignore
   localparam cmd_type CMD_SPARE = 2'd3;

   typedef struct {
      status_type status;
      value_type  top_value;
      count_type  entry_count;
   } reply_type;

   class queue_shadow;
      int        depth;
      value_type shadow_entries[];
      int        shadow_count;
      reply_type expected_replies[$];
      int        mismatch_count;

      function new(int queue_depth);
         depth          = queue_depth;
         shadow_entries = new[queue_depth];
         shadow_count   = 0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH %0t: %s", $time, what);
         mismatch_count++;
      endtask

      // update the shadow for one accepted command word and queue its reply
      function void note_command(cmd_type cmd, value_type push_value);
         reply_type reply;
         int        pos;
         reply.status    = STATUS_OK;
         reply.top_value = '0;
         if (cmd == CMD_PUSH) begin
            if (shadow_count >= depth) begin
               reply.status = STATUS_OVER;
            end else begin
               // strictly larger entries move up, so a tie lands above the old one
               pos = shadow_count;
               while (pos > 0 && push_value < shadow_entries[pos-1]) begin
                  shadow_entries[pos] = shadow_entries[pos-1];
                  pos--;
               end
               shadow_entries[pos] = push_value;
               shadow_count++;
            end
         end else if (cmd == CMD_POP || cmd == CMD_PEEK) begin
            if (shadow_count == 0) begin
               reply.status = STATUS_UNDER;
            end else begin
               reply.top_value = shadow_entries[shadow_count-1];
               if (cmd == CMD_POP) shadow_count--;
            end
         end
         reply.entry_count = count_type'(shadow_count);
         expected_replies.push_back(reply);
      endfunction

      task check_reply(status_type status, value_type top_value, count_type entry_count);
         reply_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("reply word with nothing outstanding (status %0d)",
                                      status));
         end else begin
            want = expected_replies.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (top_value !== want.top_value)
               report_mismatch($sformatf("top_value %0d, want %0d",
                                         top_value, want.top_value));
            if (entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         entry_count, want.entry_count));
         end
      endtask
   endclass

endpackage

@@ verif/sorted_priority_queue_tb.sv @@
// ---------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Directed corner commands, then random push/pop/peek traffic with idle
// bursts on both channels, a long response stall and a full drain; every
// reply is checked against a shadow queue.
// ---------------------------------------------------------------------------
module sorted_priority_queue_tb;
   import spq_pkg::*;
   import spq_tb_pkg::*;

   localparam int QueueDepth  = 4;
   localparam int RandomWords = 600;
   localparam int CalmWords   = 100;
   localparam int LongHold    = 300;
   localparam int CycleLimit  = 200000;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   bit   calm;
   bit   hold_request;

   spq_req_if req_if();
   spq_rsp_if rsp_if();

   queue_shadow shadow;

   sorted_priority_queue #(.DEPTH(QueueDepth)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("sorted_priority_queue_tb: done, errors");
         $finish;
      end
   end

   // monitors: sample both channels at the edge
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         shadow.note_command(req_if.cmd, req_if.push_value);
      if (!reset && rsp_if.valid && rsp_if.ready)
         shadow.check_reply(rsp_if.status, rsp_if.top_value, rsp_if.entry_count);
   end

   // response side: ready bursts, idle bursts, one long hold on request
   initial begin
      bit hold_done;
      hold_done    = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic issue(cmd_type cmd, value_type push_value);
      int gap;
      req_if.valid      <= 1'b1;
      req_if.cmd        <= cmd;
      req_if.push_value <= push_value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0, 1: return value_type'($signed($urandom_range(0, 6)) - 3);  // ties
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return value_type'($urandom);
      endcase
   endfunction

   // mode 0 leans to push, 1 to pop/peek, 2 even mix
   function automatic cmd_type pick_cmd(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return CMD_SPARE;
      case (mode)
         0: return (roll < 70) ? CMD_PUSH : (roll < 88) ? CMD_POP : CMD_PEEK;
         1: return (roll < 25) ? CMD_PUSH : (roll < 80) ? CMD_POP : CMD_PEEK;
         default: return (roll < 50) ? CMD_PUSH : (roll < 80) ? CMD_POP : CMD_PEEK;
      endcase
   endfunction

   initial begin
      int mode;
      shadow            = new(QueueDepth);
      calm              = 1'b0;
      hold_request      = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_PUSH;
      req_if.push_value = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty queue corners
      issue(CMD_POP, '0);
      issue(CMD_PEEK, '0);
      issue(CMD_SPARE, 32'sh1234_5678);
      // fill with the extremes, then overflow
      issue(CMD_PUSH, 32'sh7fff_ffff);
      issue(CMD_PUSH, 32'sh8000_0000);
      issue(CMD_PUSH, 32'sd0);
      issue(CMD_PUSH, -32'sd1);
      issue(CMD_PUSH, 32'sd42);
      issue(CMD_PEEK, '0);
      issue(CMD_SPARE, '0);
      repeat (QueueDepth) issue(CMD_POP, '0);
      issue(CMD_POP, '0);
      // equal values
      issue(CMD_PUSH, 32'sd5);
      issue(CMD_PUSH, 32'sd5);
      issue(CMD_PUSH, -32'sd7);
      issue(CMD_PEEK, '0);
      issue(CMD_POP, '0);
      issue(CMD_POP, '0);
      issue(CMD_POP, '0);
      issue(CMD_PEEK, '0);

      mode = 0;
      for (int i = 0; i < RandomWords; i++) begin
         if (i % 20 == 0) mode = $urandom_range(0, 2);
         if (i == 200) hold_request = 1'b1;   // receiver stalls, sender keeps offering
         if (i == 400) begin
            // stop offering so the last word is not taken again while draining
            req_if.valid <= 1'b0;
            wait_drained();
         end
         if (i == RandomWords - CalmWords) calm = 1'b1;
         issue(pick_cmd(mode), pick_value());
      end
      req_if.valid <= 1'b0;

      wait_drained();
      repeat (2 * QueueDepth + 10) @(posedge clock);
      if (shadow.mismatch_count == 0) begin
         $display("sorted_priority_queue_tb: done, clean");
      end else begin
         $display("sorted_priority_queue_tb: done, errors");
      end
      $finish;
   end

endmodule
